// ----- rtl/kfsi_pkg.sv -----
// keyframe scale interpolator package: register indexes, fixed widths and stage control
// no dependencies
`timescale 1ns / 1ps

package kfsi_pkg;

    // keyframe table size and field widths that do not vary
    localparam int NUM_POINTS     = 3;
    localparam int COUNT_BITS     = 2;
    localparam int SCALE_INT_BITS = 4;
    localparam int CFG_IDX_BITS   = 3;

    // configuration register indexes
    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_POINT_COUNT  = 3'd0,
        CFG_POINT0_TIME  = 3'd1,
        CFG_POINT1_TIME  = 3'd2,
        CFG_POINT2_TIME  = 3'd3,
        CFG_POINT0_SCALE = 3'd4,
        CFG_POINT1_SCALE = 3'd5,
        CFG_POINT2_SCALE = 3'd6,
        CFG_RUN_LENGTH   = 3'd7
    } t_cfg_reg;

    // control bits that travel with a request down the pipeline
    typedef struct packed {
        logic neg;
        logic active;
    } t_kfsi_ctl;

endpackage

// ----- rtl/kfsi_if.sv -----
// stream interfaces for the keyframe scale interpolator: time in, scale out, config writes
// depends on kfsi_pkg
`timescale 1ns / 1ps

interface kfsi_in_if #(
    parameter int TIME_BITS = 16
);
    logic                 valid;
    logic                 ready;
    logic [TIME_BITS-1:0] elapsed_ticks;

    modport source (output valid, output elapsed_ticks, input ready);
    modport sink   (input valid, input elapsed_ticks, output ready);
endinterface

interface kfsi_out_if #(
    parameter int SCALE_BITS = 16
);
    logic                  valid;
    logic                  ready;
    logic [SCALE_BITS-1:0] scale_out;
    logic                  active;

    modport source (output valid, output scale_out, output active, input ready);
    modport sink   (input valid, input scale_out, input active, output ready);
endinterface

interface kfsi_cfg_if #(
    parameter int DATA_BITS = 16
);
    logic                                  valid;
    logic                                  ready;
    logic [kfsi_pkg::CFG_IDX_BITS-1:0]     index;
    logic [DATA_BITS-1:0]                  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ----- rtl/kfsi_regs.sv -----
// configuration register file: keyframe count, times, scales and run length
// depends on kfsi_pkg and kfsi_cfg_if
`timescale 1ns / 1ps

module kfsi_regs #(
    parameter int TIME_BITS  = 16,
    parameter int SCALE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    kfsi_cfg_if.sink                        i_cfg,
    output logic [kfsi_pkg::COUNT_BITS-1:0] o_count,
    output logic [TIME_BITS-1:0]            o_time  [kfsi_pkg::NUM_POINTS],
    output logic [SCALE_BITS-1:0]           o_scale [kfsi_pkg::NUM_POINTS],
    output logic [TIME_BITS-1:0]            o_run_length
);
    import kfsi_pkg::*;

    localparam int SCALE_FRAC_BITS = SCALE_BITS - SCALE_INT_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;

    logic [COUNT_BITS-1:0] r_count;
    logic [TIME_BITS-1:0]  r_time  [NUM_POINTS];
    logic [SCALE_BITS-1:0] r_scale [NUM_POINTS];
    logic [TIME_BITS-1:0]  r_run_length;

    // writes are always taken
    assign i_cfg.ready = 1'b1;

    // register write decode
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_run_length <= '0;
            for (int k = 0; k < NUM_POINTS; k++) begin
                r_time[k]  <= '0;
                r_scale[k] <= SCALE_ONE;
            end
        end else if (i_cfg.valid) begin
            unique case (t_cfg_reg'(i_cfg.index))
                CFG_POINT_COUNT:  r_count      <= i_cfg.data[COUNT_BITS-1:0];
                CFG_POINT0_TIME:  r_time[0]    <= i_cfg.data[TIME_BITS-1:0];
                CFG_POINT1_TIME:  r_time[1]    <= i_cfg.data[TIME_BITS-1:0];
                CFG_POINT2_TIME:  r_time[2]    <= i_cfg.data[TIME_BITS-1:0];
                CFG_POINT0_SCALE: r_scale[0]   <= i_cfg.data[SCALE_BITS-1:0];
                CFG_POINT1_SCALE: r_scale[1]   <= i_cfg.data[SCALE_BITS-1:0];
                CFG_POINT2_SCALE: r_scale[2]   <= i_cfg.data[SCALE_BITS-1:0];
                CFG_RUN_LENGTH:   r_run_length <= i_cfg.data[TIME_BITS-1:0];
            endcase
        end
    end

    assign o_count      = r_count;
    assign o_time       = r_time;
    assign o_scale      = r_scale;
    assign o_run_length = r_run_length;

endmodule

// ----- rtl/kfsi_seg.sv -----
// segment select and operand prep: picks the keyframe segment, then forms dt, span and |ds|
// two register stages, depends on kfsi_pkg
`timescale 1ns / 1ps

module kfsi_seg #(
    parameter int TIME_BITS  = 16,
    parameter int SCALE_BITS = 16
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [TIME_BITS-1:0]            i_t,
    input  logic [kfsi_pkg::COUNT_BITS-1:0] i_count,
    input  logic [TIME_BITS-1:0]            i_time  [kfsi_pkg::NUM_POINTS],
    input  logic [SCALE_BITS-1:0]           i_scale [kfsi_pkg::NUM_POINTS],
    input  logic [TIME_BITS-1:0]            i_run_length,
    output logic                            o_valid,
    input  logic                            i_ready,
    output logic [TIME_BITS-1:0]            o_dt,
    output logic [TIME_BITS-1:0]            o_span,
    output logic [SCALE_BITS-1:0]           o_mag,
    output logic [SCALE_BITS-1:0]           o_base,
    output kfsi_pkg::t_kfsi_ctl             o_ctl
);
    import kfsi_pkg::*;

    localparam int SCALE_FRAC_BITS = SCALE_BITS - SCALE_INT_BITS;
    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;

    // select stage
    logic                  r1_valid;
    logic                  r1_hold;
    logic                  r1_active;
    logic [TIME_BITS-1:0]  r1_t;
    logic [TIME_BITS-1:0]  r1_prev_t;
    logic [TIME_BITS-1:0]  r1_next_t;
    logic [SCALE_BITS-1:0] r1_prev_s;
    logic [SCALE_BITS-1:0] r1_next_s;

    logic                  n1_hold;
    logic [TIME_BITS-1:0]  n1_prev_t;
    logic [TIME_BITS-1:0]  n1_next_t;
    logic [SCALE_BITS-1:0] n1_prev_s;
    logic [SCALE_BITS-1:0] n1_next_s;

    // prep stage
    logic                  r2_valid;
    logic [TIME_BITS-1:0]  r2_dt;
    logic [TIME_BITS-1:0]  r2_span;
    logic [SCALE_BITS-1:0] r2_mag;
    logic [SCALE_BITS-1:0] r2_base;
    t_kfsi_ctl             r2_ctl;

    logic                  n2_neg;
    logic [TIME_BITS-1:0]  n2_dt;
    logic [TIME_BITS-1:0]  n2_span;
    logic [SCALE_BITS-1:0] n2_mag;

    logic w_ready1;
    logic w_ready2;

    // stage enables, a bubble can be filled while the stage after stalls
    assign w_ready2 = !r2_valid || i_ready;
    assign w_ready1 = !r1_valid || w_ready2;
    assign o_ready  = w_ready1;

    // first keyframe later than t closes the segment, else hold the last passed scale
    always_comb begin
        n1_hold   = 1'b0;
        n1_prev_t = '0;
        n1_prev_s = SCALE_ONE;
        n1_next_t = i_time[0];
        n1_next_s = i_scale[0];
        priority if (i_count >= COUNT_BITS'(1) && i_time[0] > i_t) begin
            n1_prev_t = '0;
        end else if (i_count >= COUNT_BITS'(2) && i_time[1] > i_t) begin
            n1_prev_t = i_time[0];
            n1_prev_s = i_scale[0];
            n1_next_t = i_time[1];
            n1_next_s = i_scale[1];
        end else if (i_count == COUNT_BITS'(3) && i_time[2] > i_t) begin
            n1_prev_t = i_time[1];
            n1_prev_s = i_scale[1];
            n1_next_t = i_time[2];
            n1_next_s = i_scale[2];
        end else begin
            n1_hold = 1'b1;
            unique case (i_count)
                COUNT_BITS'(0): n1_prev_s = SCALE_ONE;
                COUNT_BITS'(1): n1_prev_s = i_scale[0];
                COUNT_BITS'(2): n1_prev_s = i_scale[1];
                default:        n1_prev_s = i_scale[2];
            endcase
            n1_next_s = n1_prev_s;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_valid <= 1'b0;
        end else if (w_ready1) begin
            r1_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready1 && i_valid) begin
            r1_hold   <= n1_hold;
            r1_active <= i_t < i_run_length;
            r1_t      <= i_t;
            r1_prev_t <= n1_prev_t;
            r1_next_t <= n1_next_t;
            r1_prev_s <= n1_prev_s;
            r1_next_s <= n1_next_s;
        end
    end

    // offsets within the segment and the scale step magnitude
    always_comb begin
        n2_neg  = r1_next_s < r1_prev_s;
        n2_mag  = n2_neg ? (r1_prev_s - r1_next_s) : (r1_next_s - r1_prev_s);
        n2_dt   = r1_hold ? '0 : (r1_t - r1_prev_t);
        n2_span = r1_hold ? TIME_BITS'(1) : (r1_next_t - r1_prev_t);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_valid <= 1'b0;
        end else if (w_ready2) begin
            r2_valid <= r1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready2 && r1_valid) begin
            r2_dt         <= n2_dt;
            r2_span       <= n2_span;
            r2_mag        <= n2_mag;
            r2_base       <= r1_prev_s;
            r2_ctl.neg    <= n2_neg;
            r2_ctl.active <= r1_active;
        end
    end

    assign o_valid = r2_valid;
    assign o_dt    = r2_dt;
    assign o_span  = r2_span;
    assign o_mag   = r2_mag;
    assign o_base  = r2_base;
    assign o_ctl   = r2_ctl;

    // the divide only works if the offset stays inside the segment
    a_dt_in_span: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r2_valid |-> r2_dt < r2_span)
        else $error("segment offset not below segment length");

endmodule

// ----- rtl/kfsi_mul.sv -----
// multiply stage: |ds| * dt, one register after the product
// depends on kfsi_pkg
`timescale 1ns / 1ps

module kfsi_mul #(
    parameter int TIME_BITS  = 16,
    parameter int SCALE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic [TIME_BITS-1:0]                  i_dt,
    input  logic [TIME_BITS-1:0]                  i_span,
    input  logic [SCALE_BITS-1:0]                 i_mag,
    input  logic [SCALE_BITS-1:0]                 i_base,
    input  kfsi_pkg::t_kfsi_ctl                   i_ctl,
    output logic                                  o_valid,
    input  logic                                  i_ready,
    output logic [SCALE_BITS+TIME_BITS-1:0]       o_prod,
    output logic [TIME_BITS-1:0]                  o_span,
    output logic [SCALE_BITS-1:0]                 o_base,
    output kfsi_pkg::t_kfsi_ctl                   o_ctl
);
    import kfsi_pkg::*;

    localparam int PROD_BITS = SCALE_BITS + TIME_BITS;

    logic                  r_valid;
    logic [PROD_BITS-1:0]  r_prod;
    logic [TIME_BITS-1:0]  r_span;
    logic [SCALE_BITS-1:0] r_base;
    t_kfsi_ctl             r_ctl;

    logic                  w_ready;
    logic [PROD_BITS-1:0]  w_prod;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // exact unsigned product
    assign w_prod = {{TIME_BITS{1'b0}}, i_mag} * {{SCALE_BITS{1'b0}}, i_dt};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_prod <= w_prod;
            r_span <= i_span;
            r_base <= i_base;
            r_ctl  <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_prod  = r_prod;
    assign o_span  = r_span;
    assign o_base  = r_base;
    assign o_ctl   = r_ctl;

endmodule

// ----- rtl/kfsi_div_step.sv -----
// one restoring divide step: one quotient bit per register stage
// depends on kfsi_pkg
`timescale 1ns / 1ps

module kfsi_div_step #(
    parameter int TIME_BITS  = 16,
    parameter int SCALE_BITS = 16
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [TIME_BITS-1:0]  i_rem,
    input  logic [SCALE_BITS-1:0] i_bits,
    input  logic [TIME_BITS-1:0]  i_den,
    input  logic [SCALE_BITS-1:0] i_base,
    input  kfsi_pkg::t_kfsi_ctl   i_ctl,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [TIME_BITS-1:0]  o_rem,
    output logic [SCALE_BITS-1:0] o_bits,
    output logic [TIME_BITS-1:0]  o_den,
    output logic [SCALE_BITS-1:0] o_base,
    output kfsi_pkg::t_kfsi_ctl   o_ctl
);
    import kfsi_pkg::*;

    logic                  r_valid;
    logic [TIME_BITS-1:0]  r_rem;
    logic [SCALE_BITS-1:0] r_bits;
    logic [TIME_BITS-1:0]  r_den;
    logic [SCALE_BITS-1:0] r_base;
    t_kfsi_ctl             r_ctl;

    logic                  w_ready;
    logic [TIME_BITS:0]    w_trial;
    logic [TIME_BITS:0]    w_diff;
    logic                  w_ge;
    logic [TIME_BITS-1:0]  n_rem;
    logic [SCALE_BITS-1:0] n_bits;

    assign w_ready = !r_valid || i_ready;
    assign o_ready = w_ready;

    // shift in the next dividend bit, subtract if it fits, quotient bit enters at the bottom
    always_comb begin
        w_trial = {i_rem, i_bits[SCALE_BITS-1]};
        w_diff  = w_trial - {1'b0, i_den};
        w_ge    = w_trial >= {1'b0, i_den};
        n_rem   = w_ge ? w_diff[TIME_BITS-1:0] : w_trial[TIME_BITS-1:0];
        n_bits  = {i_bits[SCALE_BITS-2:0], w_ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_ready) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_ready && i_valid) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_den  <= i_den;
            r_base <= i_base;
            r_ctl  <= i_ctl;
        end
    end

    assign o_valid = r_valid;
    assign o_rem   = r_rem;
    assign o_bits  = r_bits;
    assign o_den   = r_den;
    assign o_base  = r_base;
    assign o_ctl   = r_ctl;

    // partial remainder must stay below the divisor after every step
    a_rem_below_den: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_rem < r_den)
        else $error("partial remainder not below divisor");

    a_den_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_valid |-> r_den != '0)
        else $error("zero divisor in divide pipeline");

endmodule

// ----- rtl/keyframe_scale_interpolator_top.sv -----
// keyframe scale interpolator: a request passes select, prep, multiply, one divide stage per
// quotient bit and output; throughput one request per cycle while the output is not stalled
// every stage has its own valid bit and fills its bubbles
// config writes are taken every cycle and act on requests accepted after them
// synchronous active-low reset empties the pipeline and loads the register reset values
// depends on kfsi_pkg, kfsi_if, kfsi_regs, kfsi_seg, kfsi_mul, kfsi_div_step
`timescale 1ns / 1ps

module keyframe_scale_interpolator_top #(
    parameter int TIME_BITS       = 16,
    parameter int SCALE_FRAC_BITS = 12
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    kfsi_in_if.sink    i_in,
    kfsi_out_if.source o_out,
    kfsi_cfg_if.sink   i_cfg
);
    import kfsi_pkg::*;

    localparam int SCALE_BITS = SCALE_FRAC_BITS + SCALE_INT_BITS;
    localparam int PROD_BITS  = SCALE_BITS + TIME_BITS;

    // configuration
    logic [COUNT_BITS-1:0] w_count;
    logic [TIME_BITS-1:0]  w_time  [NUM_POINTS];
    logic [SCALE_BITS-1:0] w_scale [NUM_POINTS];
    logic [TIME_BITS-1:0]  w_run_length;

    // segment to multiply
    logic                  w_seg_valid;
    logic                  w_seg_ready;
    logic [TIME_BITS-1:0]  w_seg_dt;
    logic [TIME_BITS-1:0]  w_seg_span;
    logic [SCALE_BITS-1:0] w_seg_mag;
    logic [SCALE_BITS-1:0] w_seg_base;
    t_kfsi_ctl             w_seg_ctl;

    // multiply to divide
    logic                  w_mul_valid;
    logic [PROD_BITS-1:0]  w_mul_prod;
    logic [TIME_BITS-1:0]  w_mul_span;
    logic [SCALE_BITS-1:0] w_mul_base;
    t_kfsi_ctl             w_mul_ctl;

    // divide chain, entry k feeds step k
    logic                  w_dv_valid [SCALE_BITS+1];
    logic                  w_dv_ready [SCALE_BITS+1];
    logic [TIME_BITS-1:0]  w_dv_rem   [SCALE_BITS+1];
    logic [SCALE_BITS-1:0] w_dv_bits  [SCALE_BITS+1];
    logic [TIME_BITS-1:0]  w_dv_den   [SCALE_BITS+1];
    logic [SCALE_BITS-1:0] w_dv_base  [SCALE_BITS+1];
    t_kfsi_ctl             w_dv_ctl   [SCALE_BITS+1];

    // output stage
    logic                  r_valid;
    logic [SCALE_BITS-1:0] r_scale;
    logic                  r_active;
    logic                  w_out_ready;
    logic [SCALE_BITS:0]   w_sum;
    logic [SCALE_BITS-1:0] w_quot;
    logic [SCALE_BITS-1:0] n_scale;

    kfsi_regs #(
        .TIME_BITS  (TIME_BITS),
        .SCALE_BITS (SCALE_BITS)
    ) u_regs (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg        (i_cfg),
        .o_count      (w_count),
        .o_time       (w_time),
        .o_scale      (w_scale),
        .o_run_length (w_run_length)
    );

    kfsi_seg #(
        .TIME_BITS  (TIME_BITS),
        .SCALE_BITS (SCALE_BITS)
    ) u_seg (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_in.valid),
        .o_ready      (i_in.ready),
        .i_t          (i_in.elapsed_ticks),
        .i_count      (w_count),
        .i_time       (w_time),
        .i_scale      (w_scale),
        .i_run_length (w_run_length),
        .o_valid      (w_seg_valid),
        .i_ready      (w_seg_ready),
        .o_dt         (w_seg_dt),
        .o_span       (w_seg_span),
        .o_mag        (w_seg_mag),
        .o_base       (w_seg_base),
        .o_ctl        (w_seg_ctl)
    );

    kfsi_mul #(
        .TIME_BITS  (TIME_BITS),
        .SCALE_BITS (SCALE_BITS)
    ) u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_seg_valid),
        .o_ready (w_seg_ready),
        .i_dt    (w_seg_dt),
        .i_span  (w_seg_span),
        .i_mag   (w_seg_mag),
        .i_base  (w_seg_base),
        .i_ctl   (w_seg_ctl),
        .o_valid (w_mul_valid),
        .i_ready (w_dv_ready[0]),
        .o_prod  (w_mul_prod),
        .o_span  (w_mul_span),
        .o_base  (w_mul_base),
        .o_ctl   (w_mul_ctl)
    );

    // quotient is below |ds|, so the high product bits start out below the divisor
    assign w_dv_valid[0] = w_mul_valid;
    assign w_dv_rem[0]   = w_mul_prod[PROD_BITS-1:SCALE_BITS];
    assign w_dv_bits[0]  = w_mul_prod[SCALE_BITS-1:0];
    assign w_dv_den[0]   = w_mul_span;
    assign w_dv_base[0]  = w_mul_base;
    assign w_dv_ctl[0]   = w_mul_ctl;

    for (genvar k = 0; k < SCALE_BITS; k++) begin : g_div
        kfsi_div_step #(
            .TIME_BITS  (TIME_BITS),
            .SCALE_BITS (SCALE_BITS)
        ) u_step (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_valid (w_dv_valid[k]),
            .o_ready (w_dv_ready[k]),
            .i_rem   (w_dv_rem[k]),
            .i_bits  (w_dv_bits[k]),
            .i_den   (w_dv_den[k]),
            .i_base  (w_dv_base[k]),
            .i_ctl   (w_dv_ctl[k]),
            .o_valid (w_dv_valid[k+1]),
            .i_ready (w_dv_ready[k+1]),
            .o_rem   (w_dv_rem[k+1]),
            .o_bits  (w_dv_bits[k+1]),
            .o_den   (w_dv_den[k+1]),
            .o_base  (w_dv_base[k+1]),
            .o_ctl   (w_dv_ctl[k+1])
        );
    end

    // apply the signed step to the segment start scale
    assign w_out_ready            = !r_valid || o_out.ready;
    assign w_dv_ready[SCALE_BITS] = w_out_ready;
    assign w_quot                 = w_dv_bits[SCALE_BITS];

    always_comb begin
        w_sum   = {1'b0, w_dv_base[SCALE_BITS]} + {1'b0, w_quot};
        n_scale = w_dv_ctl[SCALE_BITS].neg ? (w_dv_base[SCALE_BITS] - w_quot)
                                           : w_sum[SCALE_BITS-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (w_out_ready) begin
            r_valid <= w_dv_valid[SCALE_BITS];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_ready && w_dv_valid[SCALE_BITS]) begin
            r_scale  <= n_scale;
            r_active <= w_dv_ctl[SCALE_BITS].active;
        end
    end

    assign o_out.valid     = r_valid;
    assign o_out.scale_out = r_scale;
    assign o_out.active    = r_active;

    // interpolated scale lies between the two keyframe scales, so no wrap either way
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_valid[SCALE_BITS] && !w_dv_ctl[SCALE_BITS].neg |-> !w_sum[SCALE_BITS])
        else $error("rising segment overflowed the scale range");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_dv_valid[SCALE_BITS] && w_dv_ctl[SCALE_BITS].neg |-> w_quot <= w_dv_base[SCALE_BITS])
        else $error("falling segment went below zero");

endmodule

// ----- tb/keyframe_scale_interpolator_top_tb.sv -----
// self-checking testbench for keyframe_scale_interpolator_top: directed and random elapsed-tick requests
// are checked against an in-bench keyframe interpolation predictor
// depends on kfsi_pkg, kfsi_if and the keyframe_scale_interpolator_top rtl
`timescale 1ns / 1ps

module keyframe_scale_interpolator_top_tb;

    import kfsi_pkg::*;

    localparam int TIME_BITS       = 16;
    localparam int SCALE_FRAC_BITS = 12;
    localparam int SCALE_BITS      = SCALE_FRAC_BITS + SCALE_INT_BITS;
    localparam int PIPE_LATENCY    = SCALE_FRAC_BITS + 8;
    localparam int MAX_GAP         = 13;
    localparam int LONG_HOLD       = 300;
    localparam int RANDOM_PHASES   = 12;
    localparam int PHASE_ITEMS     = 72;
    localparam int CYCLE_LIMIT     = 400000;

    localparam logic [SCALE_BITS-1:0] SCALE_ONE = SCALE_BITS'(1) << SCALE_FRAC_BITS;

    // one expected result, tagged with the request that caused it
    typedef struct packed {
        logic [TIME_BITS-1:0]  ticks;
        logic [SCALE_BITS-1:0] scale;
        logic                  active;
    } t_scale_result;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    kfsi_in_if  #(.TIME_BITS(TIME_BITS))  in_bus ();
    kfsi_out_if #(.SCALE_BITS(SCALE_BITS)) out_bus ();
    kfsi_cfg_if #(.DATA_BITS(TIME_BITS))  cfg_bus ();

    keyframe_scale_interpolator_top #(
        .TIME_BITS      (TIME_BITS),
        .SCALE_FRAC_BITS(SCALE_FRAC_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_bus),
        .o_out  (out_bus),
        .i_cfg  (cfg_bus)
    );

    // shadow copy of the keyframe registers
    logic [1:0]            kf_count;
    logic [TIME_BITS-1:0]  kf_time  [NUM_POINTS];
    logic [SCALE_BITS-1:0] kf_scale [NUM_POINTS];
    logic [TIME_BITS-1:0]  run_ticks;

    logic [TIME_BITS-1:0] tick_queue [$];
    t_scale_result        expected_scales [$];
    int  ticks_queued    = 0;
    int  ticks_accepted  = 0;
    int  mismatch_count  = 0;
    int  cycle_count     = 0;
    int  send_gap        = 0;
    int  recv_gap        = 0;
    bit  sender_idle     = 1'b0;
    bit  receiver_idle   = 1'b0;
    logic tick_taken     = 1'b0;
    logic scale_taken    = 1'b0;
    logic long_hold      = 1'b0;
    event hold_ev;

    // clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // piecewise linear scale over the keyframes, starting from (0, 1.0)
    function automatic t_scale_result predict_scale(input logic [TIME_BITS-1:0] t);
        t_scale_result r;
        longint prev_t;
        longint prev_s;
        longint span;
        longint dt;
        longint diff;
        bit     done;
        prev_t  = 0;
        prev_s  = longint'(SCALE_ONE);
        done    = 1'b0;
        r.ticks = t;
        r.scale = SCALE_ONE;
        for (int i = 0; i < NUM_POINTS; i++) begin
            if (!done && i < int'(kf_count)) begin
                if (kf_time[i] > t) begin
                    // segment closes here: truncating signed division
                    span    = longint'(kf_time[i]) - prev_t;
                    dt      = longint'(t) - prev_t;
                    diff    = longint'(kf_scale[i]) - prev_s;
                    r.scale = SCALE_BITS'(prev_s + (diff * dt) / span);
                    done    = 1'b1;
                end else begin
                    prev_t = longint'(kf_time[i]);
                    prev_s = longint'(kf_scale[i]);
                end
            end
        end
        // past the last keyframe, hold its scale
        if (!done)
            r.scale = SCALE_BITS'(prev_s);
        r.active = (t < run_ticks);
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        mismatch_count++;
    endtask

    // one register write on the config channel, shadow updated on acceptance
    task automatic write_reg(input t_cfg_reg idx, input logic [TIME_BITS-1:0] value);
        @(negedge i_clk);
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge i_clk); while (!cfg_bus.ready);
        case (idx)
            CFG_POINT_COUNT:  kf_count    = value[1:0];
            CFG_POINT0_TIME:  kf_time[0]  = value;
            CFG_POINT1_TIME:  kf_time[1]  = value;
            CFG_POINT2_TIME:  kf_time[2]  = value;
            CFG_POINT0_SCALE: kf_scale[0] = value;
            CFG_POINT1_SCALE: kf_scale[1] = value;
            CFG_POINT2_SCALE: kf_scale[2] = value;
            CFG_RUN_LENGTH:   run_ticks   = value;
            default: ;
        endcase
        @(negedge i_clk);
        cfg_bus.valid <= 1'b0;
    endtask

    task automatic write_keyframes(input logic [TIME_BITS-1:0] count,
                                   input logic [TIME_BITS-1:0] t0, t1, t2,
                                   input logic [TIME_BITS-1:0] s0, s1, s2,
                                   input logic [TIME_BITS-1:0] run);
        write_reg(CFG_POINT_COUNT, count);
        write_reg(CFG_POINT0_TIME, t0);
        write_reg(CFG_POINT1_TIME, t1);
        write_reg(CFG_POINT2_TIME, t2);
        write_reg(CFG_POINT0_SCALE, s0);
        write_reg(CFG_POINT1_SCALE, s1);
        write_reg(CFG_POINT2_SCALE, s2);
        write_reg(CFG_RUN_LENGTH, run);
    endtask

    task automatic queue_tick(input logic [TIME_BITS-1:0] t);
        tick_queue.push_back(t);
        ticks_queued++;
    endtask

    // wait until every queued request is in and every result is out
    task automatic wait_idle();
        while (ticks_accepted != ticks_queued || expected_scales.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic logic [TIME_BITS-1:0] pick_time();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            2:       return TIME_BITS'($urandom_range(0, 255));
            3:       return TIME_BITS'($urandom_range(65280, 65535));
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    function automatic logic [TIME_BITS-1:0] pick_scale();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2:       return SCALE_ONE;
            default: return TIME_BITS'($urandom);
        endcase
    endfunction

    // random keyframe set, mostly in ascending time order
    task automatic randomize_keyframes(input bit ascending);
        logic [TIME_BITS-1:0] tt [NUM_POINTS];
        logic [TIME_BITS-1:0] swap;
        for (int i = 0; i < NUM_POINTS; i++)
            tt[i] = pick_time();
        if (ascending) begin
            for (int a = 0; a < NUM_POINTS - 1; a++) begin
                for (int b = 0; b < NUM_POINTS - 1 - a; b++) begin
                    if (tt[b] > tt[b + 1]) begin
                        swap      = tt[b];
                        tt[b]     = tt[b + 1];
                        tt[b + 1] = swap;
                    end
                end
            end
        end
        // upper data bits are junk for the count register
        write_keyframes({TIME_BITS'($urandom) & ~TIME_BITS'(3)} | TIME_BITS'($urandom_range(0, 3)),
                        tt[0], tt[1], tt[2], pick_scale(), pick_scale(), pick_scale(),
                        pick_time());
    endtask

    // ticks spread over the whole range and clustered on keyframe and run edges
    task automatic queue_random_ticks(input int n);
        int k;
        for (int i = 0; i < n; i++) begin
            case ($urandom_range(0, 9))
                0, 1, 2, 3: queue_tick(TIME_BITS'($urandom));
                4, 5, 6: begin
                    k = $urandom_range(0, NUM_POINTS - 1);
                    queue_tick(TIME_BITS'(int'(kf_time[k]) + $urandom_range(0, 2) - 1));
                end
                7:       queue_tick(TIME_BITS'(int'(run_ticks) + $urandom_range(0, 2) - 1));
                8:       queue_tick($urandom_range(0, 1) ? '1 : '0);
                default: queue_tick(TIME_BITS'($urandom_range(0, 255)));
            endcase
        end
    endtask

    // request driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            in_bus.valid         <= 1'b0;
            in_bus.elapsed_ticks <= '0;
            send_gap = 0;
        end else if (!(in_bus.valid && !tick_taken)) begin
            if (send_gap > 0) begin
                in_bus.valid <= 1'b0;
                send_gap--;
            end else if (tick_queue.size() > 0) begin
                in_bus.valid         <= 1'b1;
                in_bus.elapsed_ticks <= tick_queue.pop_front();
                send_gap = sender_idle ? $urandom_range(0, MAX_GAP) : 0;
            end else begin
                in_bus.valid <= 1'b0;
            end
        end
    end

    // result receiver with per-result stalls
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            out_bus.ready <= 1'b0;
            recv_gap = 0;
        end else begin
            if (scale_taken)
                recv_gap = receiver_idle ? $urandom_range(0, MAX_GAP) : 0;
            if (long_hold) begin
                out_bus.ready <= 1'b0;
            end else if (recv_gap > 0) begin
                out_bus.ready <= 1'b0;
                recv_gap--;
            end else begin
                out_bus.ready <= 1'b1;
            end
        end
    end

    // long receiver hold-off so the pipeline backs up into the input
    initial begin : receiver_hold
        forever begin
            @(hold_ev);
            @(negedge i_clk);
            long_hold <= 1'b1;
            repeat (LONG_HOLD) @(negedge i_clk);
            long_hold <= 1'b0;
        end
    end

    // request and result monitor, plus run limit
    always @(posedge i_clk) begin : scale_monitor
        t_scale_result want;
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("FAIL keyframe_scale_interpolator_top");
            $finish;
        end else if (!i_rst_n) begin
            tick_taken  <= 1'b0;
            scale_taken <= 1'b0;
        end else begin
            tick_taken  <= in_bus.valid && in_bus.ready;
            scale_taken <= out_bus.valid && out_bus.ready;
            if (in_bus.valid && in_bus.ready) begin
                expected_scales.push_back(predict_scale(in_bus.elapsed_ticks));
                ticks_accepted++;
            end
            if (out_bus.valid && out_bus.ready) begin
                if (expected_scales.size() == 0) begin
                    report_mismatch($sformatf("result scale %0d active %0b with no request",
                                              out_bus.scale_out, out_bus.active));
                end else begin
                    want = expected_scales.pop_front();
                    if (out_bus.scale_out !== want.scale)
                        report_mismatch($sformatf("ticks %0d: scale_out %0d, expected %0d",
                                                  want.ticks, out_bus.scale_out, want.scale));
                    if (out_bus.active !== want.active)
                        report_mismatch($sformatf("ticks %0d: active %b, expected %b",
                                                  want.ticks, out_bus.active, want.active));
                end
            end
        end
    end

    // stimulus
    initial begin : stimulus
        in_bus.valid         = 1'b0;
        in_bus.elapsed_ticks = '0;
        out_bus.ready        = 1'b0;
        cfg_bus.valid        = 1'b0;
        cfg_bus.index        = CFG_POINT_COUNT;
        cfg_bus.data         = '0;
        kf_count  = '0;
        run_ticks = '0;
        for (int i = 0; i < NUM_POINTS; i++) begin
            kf_time[i]  = '0;
            kf_scale[i] = SCALE_ONE;
        end

        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset values: no keyframes, run length zero
        queue_tick('0);
        queue_tick('1);
        wait_idle();

        // ascending keyframes: ramp down, ramp up to max, ramp back, held after last
        write_keyframes(16'd3, 16'd100, 16'd200, 16'd300, 16'd0, 16'hFFFF, 16'd8192, 16'd250);
        queue_tick(16'd0);
        queue_tick(16'd50);
        queue_tick(16'd99);
        queue_tick(16'd100);
        queue_tick(16'd150);
        queue_tick(16'd199);
        queue_tick(16'd200);
        queue_tick(16'd249);
        queue_tick(16'd250);
        queue_tick(16'd299);
        queue_tick(16'd300);
        queue_tick(16'hFFFF);
        wait_idle();

        // keyframe times out of order, count written with junk upper bits
        write_keyframes(16'hFFFF, 16'd500, 16'd100, 16'hFFFF,
                        16'hFFFF, 16'd0, 16'h1234, 16'hFFFF);
        queue_tick(16'd0);
        queue_tick(16'd499);
        queue_tick(16'd500);
        queue_tick(16'd600);
        queue_tick(16'hFFFE);
        queue_tick(16'hFFFF);
        wait_idle();

        // single keyframe at time zero is passed at once
        write_reg(CFG_POINT_COUNT, 16'd1);
        write_reg(CFG_POINT0_TIME, 16'd0);
        queue_tick(16'd0);
        queue_tick(16'd40000);
        wait_idle();

        // random phases with changing keyframes and idling mixes
        for (int p = 0; p < RANDOM_PHASES; p++) begin
            sender_idle   = p[0];
            receiver_idle = p[1];
            if (p == 0)
                write_keyframes(16'd3, '1, '1, '1, '1, '1, '1, '1);
            else if (p == 1)
                write_keyframes(16'hFFFC, '0, '0, '0, '0, '0, '0, '0);
            else
                randomize_keyframes($urandom_range(0, 3) != 0);
            if (p == 4 || p == 9) begin
                sender_idle = 1'b0;
                queue_random_ticks(PHASE_ITEMS);
                -> hold_ev;
            end else begin
                queue_random_ticks(PHASE_ITEMS);
            end
            wait_idle();
        end

        // drain and watch for stray results
        repeat (2 * PIPE_LATENCY) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("PASS keyframe_scale_interpolator_top");
        else
            $display("FAIL keyframe_scale_interpolator_top");
        $finish;
    end

endmodule
